[rtl/sse_pkg.sv]
// Shared types and constants for the selection sort engine.
// No dependencies; imported by sse_core and the top level.
`timescale 1ns / 1ps

package sse_pkg;

	// Default capacity of the element memory and the data width of one element
	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned VAL_W     = 32;

	// Input transfer payload
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} in_item_t;

	// Output transfer payload
	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    final_res;
		logic                    dropped;
	} out_item_t;

	// Emit strobe from the sequencer to the result register
	typedef struct packed {
		logic vld;
		logic final_res;
		logic dropped;
	} emit_t;

	// Sequencer states
	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SWAP1 = 6'b000100,
		S_SWAP2 = 6'b001000,
		S_ERD   = 6'b010000,
		S_EWAIT = 6'b100000
	} state_t;

endpackage

[rtl/sse_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module sse_ram #(
	parameter int unsigned W  = 32,
	parameter int unsigned D  = 64,
	localparam int unsigned AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sse_core.sv]
// Load / sort / emit sequencer of the selection sort engine.
// Drives the element RAM ports; depends on sse_pkg.
`timescale 1ns / 1ps

module sse_core #(
	parameter int unsigned DEPTH = sse_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     src_valid,
	output logic                     src_stall,
	input  sse_pkg::in_item_t        src_item,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [sse_pkg::VAL_W-1:0] ram_wdata,
	output logic                     ram_re,
	output logic [AW-1:0]            ram_raddr,
	input  logic [sse_pkg::VAL_W-1:0] ram_rdata,
	output sse_pkg::emit_t           emit,
	input  logic                     out_free
);

	import sse_pkg::*;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic                    ovf_q;
	logic [AW-1:0]           pos_q;
	logic [CW-1:0]           issue_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic signed [VAL_W-1:0] small_q;
	logic [VAL_W-1:0]        posval_q;
	logic [AW-1:0]           best_q;
	logic [CW-1:0]           k_q;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] n_load;
	logic          issue_more;
	logic          scan_first;
	logic          take_lower;
	logic [CW-1:0] pos_inc;
	logic [CW-1:0] pos_next2;
	logic [CW-1:0] k_inc;
	logic          emit_take;
	logic          is_last_res;

	// Handshake and shared arithmetic
	assign src_stall   = (state_q != S_LOAD);
	assign accept      = src_valid && (state_q == S_LOAD);
	assign has_room    = (cnt_q != CW'(DEPTH));
	assign cnt_inc     = cnt_q + CW'(1);
	assign n_load      = has_room ? cnt_inc : cnt_q;
	assign issue_more  = (issue_q != cnt_q);
	assign scan_first  = rd_vld_s1 && (rd_idx_s1 == pos_q);
	assign take_lower  = rd_vld_s1 && !scan_first && ($signed(ram_rdata) < small_q);
	assign pos_inc     = CW'(pos_q) + CW'(1);
	assign pos_next2   = pos_inc + CW'(1);
	assign k_inc       = k_q + CW'(1);
	assign is_last_res = (k_inc == cnt_q);
	assign emit_take   = (state_q == S_EWAIT) && out_free;

	// RAM write port: load, then the two halves of a swap
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = src_item.value;
		unique case (state_q)
			S_LOAD: begin
				ram_we = accept && has_room;
			end
			S_SWAP1: begin
				ram_we    = (best_q != pos_q);
				ram_waddr = pos_q;
				ram_wdata = small_q;
			end
			S_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = best_q;
				ram_wdata = posval_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// RAM read port: scan reads and emit reads
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = issue_q[AW-1:0];
		unique case (state_q)
			S_SCAN: begin
				ram_re = issue_more;
			end
			S_ERD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q[AW-1:0];
			end
			S_EWAIT: begin
				ram_re    = out_free && !is_last_res;
				ram_raddr = k_inc[AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Result strobe; the value itself is the RAM read data
	assign emit.vld       = emit_take;
	assign emit.final_res = is_last_res;
	assign emit.dropped   = ovf_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			pos_q     <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			k_q       <= '0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							cnt_q <= cnt_inc;
						end else begin
							ovf_q <= 1'b1;
						end
						if (src_item.last) begin
							pos_q   <= '0;
							issue_q <= '0;
							k_q     <= '0;
							if (n_load < CW'(2)) begin
								state_q <= S_ERD;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (issue_more) begin
						issue_q <= issue_q + CW'(1);
					end
					rd_vld_s1 <= issue_more;
					if (!issue_more && !rd_vld_s1) begin
						state_q <= S_SWAP1;
					end
				end
				S_SWAP1, S_SWAP2: begin
					if (state_q == S_SWAP1 && best_q != pos_q) begin
						state_q <= S_SWAP2;
					end else begin
						// next position
						pos_q   <= pos_inc[AW-1:0];
						issue_q <= pos_inc;
						if (pos_next2 < cnt_q) begin
							state_q <= S_SCAN;
						end else begin
							k_q     <= '0;
							state_q <= S_ERD;
						end
					end
				end
				S_ERD: begin
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					if (out_free) begin
						if (is_last_res) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Scan pipeline payload: index of the read in flight and running minimum
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[AW-1:0];
		if (state_q == S_SCAN) begin
			if (scan_first) begin
				small_q  <= $signed(ram_rdata);
				posval_q <= ram_rdata;
				best_q   <= pos_q;
			end else if (take_lower) begin
				small_q <= $signed(ram_rdata);
				best_q  <= rd_idx_s1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CW'(DEPTH)))
		else $error("overflow flagged with room left");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP1) |-> (CW'(best_q) < cnt_q && best_q >= pos_q))
		else $error("selected index outside the unsorted range");

	a_final_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.vld && emit.final_res) |=> (state_q == S_LOAD && cnt_q == '0))
		else $error("run not closed after its final result");
`endif

endmodule

[rtl/selection_sort_engine_top.sv]
// Top level of the selection sort engine: element RAM, sequencer, result register.
// Depends on sse_pkg, sse_ram and sse_core.
`timescale 1ns / 1ps

// Values arrive one per cycle on the source channel and are written into the
// element RAM until an item with last set closes the run; values past DEPTH
// are discarded and every result of that run then carries dropped. The block
// then stalls its input and sorts in place: for position p of an n-entry run
// the single RAM read port streams entries p..n-1 one per cycle, then the read
// pipeline drains and the swap is written as two RAM writes, or skipped when
// the minimum already sits at p. The run then leaves in ascending signed order,
// after an initial read, at one result per cycle while the output is not
// stalled, with final_res on the last one. Input is taken again as soon as the
// final result sits in the output register.
module selection_sort_engine_top #(
	parameter int unsigned DEPTH = sse_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sse_pkg::in_item_t  src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output sse_pkg::out_item_t res_item
);

	import sse_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;
	emit_t            emit;
	logic             out_free;
	logic             res_vld_q;
	out_item_t        res_q;

	sse_ram #(
		.W (VAL_W),
		.D (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sse_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.emit      (emit),
		.out_free  (out_free)
	);

	// Result register: free when empty or its transfer completes this cycle
	assign out_free = !res_vld_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit.vld) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.vld) begin
			res_q.sorted_value <= $signed(ram_rdata);
			res_q.final_res    <= emit.final_res;
			res_q.dropped      <= emit.dropped;
		end
	end

	assign res_valid = res_vld_q;
	assign res_item  = res_q;

endmodule
